FILE: hdl/integer_instruction_execute_unit_defines.svh
// Assertion macros for the integer instruction execute unit checker.
// No dependencies; each macro expects clk and rst in scope.
`ifndef INTEGER_INSTRUCTION_EXECUTE_UNIT_DEFINES_SVH
`define INTEGER_INSTRUCTION_EXECUTE_UNIT_DEFINES_SVH

// Same-cycle implication.
`define IIEU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define IIEU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/iieu_pkg.sv
// Shared types and constants of the integer instruction execute unit.
// No dependencies; used by every module of the block.
package iieu_pkg;

  localparam int XLEN        = 32;
  localparam int REG_AW      = 5;
  localparam int LINE_FIELD_W = 14;

  localparam logic [3:0] ACT_ADD  = 4'd0;
  localparam logic [3:0] ACT_SUB  = 4'd1;
  localparam logic [3:0] ACT_MUL  = 4'd2;
  localparam logic [3:0] ACT_DIV  = 4'd3;
  localparam logic [3:0] ACT_ADDI = 4'd4;
  localparam logic [3:0] ACT_BEQ  = 4'd5;
  localparam logic [3:0] ACT_BNE  = 4'd6;
  localparam logic [3:0] ACT_J    = 4'd7;
  localparam logic [3:0] ACT_LW   = 4'd8;
  localparam logic [3:0] ACT_SW   = 4'd9;
  localparam logic [3:0] ACT_SLT  = 4'd10;
  localparam logic [3:0] ACT_LA   = 4'd11;
  localparam logic [3:0] ACT_JR   = 4'd12;

  localparam logic [1:0] FAULT_NONE  = 2'd0;
  localparam logic [1:0] FAULT_DIV0  = 2'd1;
  localparam logic [1:0] FAULT_RANGE = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_MEM,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic rd;
    logic wr;
  } mem_cmd_t;

endpackage

FILE: hdl/iieu_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on iieu_pkg.
module iieu_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic signed [iieu_pkg::XLEN-1:0] dividend,
  input  logic signed [iieu_pkg::XLEN-1:0] divisor,
  output logic                           done,
  output logic        [iieu_pkg::XLEN-1:0] quotient
);
  import iieu_pkg::*;

  localparam int CW = $clog2(XLEN);

  logic            busy;
  logic [CW-1:0]   cnt;
  logic            neg;
  logic [XLEN-1:0] rem;
  logic [XLEN-1:0] quo;
  logic [XLEN-1:0] dvs;
  logic [XLEN-1:0] mag_a;
  logic [XLEN-1:0] mag_b;
  logic [XLEN-1:0] rem_sh;
  logic [XLEN:0]   trial;

  always_comb begin
    mag_a  = dividend[XLEN-1] ? XLEN'(-dividend) : dividend;
    mag_b  = divisor[XLEN-1]  ? XLEN'(-divisor)  : divisor;
    rem_sh = {rem[XLEN-2:0], quo[XLEN-1]};
    trial  = {1'b0, rem_sh} - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(XLEN - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[XLEN-1] ^ divisor[XLEN-1];
      rem <= '0;
      quo <= mag_a;
      dvs <= mag_b;
    end else if (busy) begin
      if (!trial[XLEN]) begin
        rem <= trial[XLEN-1:0];
        quo <= {quo[XLEN-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[XLEN-2:0], 1'b0};
      end
    end
  end

  assign quotient = neg ? XLEN'(-quo) : quo;

endmodule

FILE: hdl/iieu_rf.sv
// Register file: 32 words, two registered read ports, one write port.
// Depends on iieu_pkg; entries read as zero until first written.
module iieu_rf (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             re,
  input  logic [iieu_pkg::REG_AW-1:0]      ra,
  input  logic [iieu_pkg::REG_AW-1:0]      rb,
  input  logic                             we,
  input  logic [iieu_pkg::REG_AW-1:0]      wa,
  input  logic [iieu_pkg::XLEN-1:0]        wd,
  output logic [iieu_pkg::XLEN-1:0]        rdata_a,
  output logic [iieu_pkg::XLEN-1:0]        rdata_b
);
  import iieu_pkg::*;

  localparam int DEPTH = 1 << REG_AW;

  logic [XLEN-1:0]  mem [DEPTH];
  logic [DEPTH-1:0] valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rdata_a <= valid[ra] ? mem[ra] : '0;
      rdata_b <= valid[rb] ? mem[rb] : '0;
    end
  end

endmodule

FILE: hdl/iieu_dmem.sv
// Data memory with one registered read port, one write port and a clearing
// sweep after reset. Depends on iieu_pkg.
module iieu_dmem #(
  parameter int MEM_WORDS = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  iieu_pkg::mem_cmd_t            cmd,
  input  logic [$clog2(MEM_WORDS)-1:0]  addr,
  input  logic [iieu_pkg::XLEN-1:0]     wdata,
  output logic [iieu_pkg::XLEN-1:0]     rdata,
  output logic                          busy
);
  import iieu_pkg::*;

  localparam int AW = $clog2(MEM_WORDS);

  logic [XLEN-1:0] mem [MEM_WORDS];
  logic [AW-1:0]   clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      if (clr_addr == AW'(MEM_WORDS - 1)) begin
        busy <= 1'b0;
      end else begin
        clr_addr <= clr_addr + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= '0;
    end else if (cmd.wr) begin
      mem[addr] <= wdata;
    end
    if (cmd.rd) begin
      rdata <= mem[addr];
    end
  end

endmodule

FILE: hdl/integer_instruction_execute_unit.sv
// Integer instruction execute unit: sequencer, ALU and output register.
// Depends on iieu_pkg, iieu_rf, iieu_dmem and iieu_div.
//
// Each input transaction carries one decoded instruction and yields exactly
// one output transaction with the new line counter, the taken and wrote flags,
// the written value and a fault code. Instructions run one at a time.
// An instruction is accepted in ST_IDLE, its operands come from the register
// file in ST_EXEC, and it retires into the output register from ST_DONE. A
// load also passes through ST_MEM for the data memory read port, and a
// division that is not by zero waits in ST_DIV for the bit-serial divider.
// The output register lets a new instruction be accepted while the previous
// result still waits; if the receiver stalls, the next instruction holds in
// its final cycle until the output register is free.
// After reset the data memory is swept to zero, one word per cycle; no
// instruction is accepted until the sweep ends.
// Writing start_line over the APB port loads the line counter.
module integer_instruction_execute_unit #(
  parameter int MEM_WORDS = 1024,
  parameter int LINE_BITS = 14
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [3:0]                           action,
  input  logic [iieu_pkg::REG_AW-1:0]          dest_reg,
  input  logic [iieu_pkg::REG_AW-1:0]          source_a,
  input  logic [iieu_pkg::REG_AW-1:0]          source_b,
  input  logic signed [15:0]                   immediate,
  input  logic [iieu_pkg::LINE_FIELD_W-1:0]    branch_target,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [iieu_pkg::LINE_FIELD_W-1:0]    next_line,
  output logic                                 taken,
  output logic                                 wrote,
  output logic signed [iieu_pkg::XLEN-1:0]     write_value,
  output logic [1:0]                           fault,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [2:0]                           paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);
  import iieu_pkg::*;

  localparam int AW = $clog2(MEM_WORDS);
  localparam int LW = (LINE_BITS > LINE_FIELD_W) ? LINE_BITS : LINE_FIELD_W;
  localparam logic CFG_START_LINE = 1'b0;

  state_t state, state_next;

  logic [3:0]              act_q;
  logic [REG_AW-1:0]       rd_q;
  logic [15:0]             imm_q;
  logic [LINE_FIELD_W-1:0] tgt_q;

  logic [LINE_FIELD_W-1:0] start_line;
  logic [LINE_BITS-1:0]    program_line;
  logic [LINE_BITS-1:0]    line_next;

  logic [XLEN-1:0] va, vb;
  logic [XLEN-1:0] imm_ext, sum, sum_adj, word_q, prod;
  logic            idx_ok;
  logic [XLEN-1:0] exec_value;
  logic            exec_write, exec_taken;
  logic [1:0]      exec_fault;

  logic [XLEN-1:0] res_value;
  logic            res_write, res_taken;
  logic [1:0]      res_fault;

  logic            accept, retire, cfg_wr, div_start, div_done, dmem_busy;
  mem_cmd_t        mem_cmd;
  logic [XLEN-1:0] div_quotient, dmem_rdata;
  logic [LW-1:0]   cfg_line_ext, tgt_ext, line_next_ext;

  iieu_rf u_rf (
    .clk     (clk),
    .rst     (rst),
    .re      (accept),
    .ra      (source_a),
    .rb      (source_b),
    .we      (retire && res_write),
    .wa      (rd_q),
    .wd      (res_value),
    .rdata_a (va),
    .rdata_b (vb)
  );

  iieu_dmem #(.MEM_WORDS(MEM_WORDS)) u_dmem (
    .clk   (clk),
    .rst   (rst),
    .cmd   (mem_cmd),
    .addr  (word_q[AW-1:0]),
    .wdata (vb),
    .rdata (dmem_rdata),
    .busy  (dmem_busy)
  );

  iieu_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (va),
    .divisor  (vb),
    .done     (div_done),
    .quotient (div_quotient)
  );

  assign pready        = 1'b1;
  assign cfg_wr        = psel && penable && pwrite && pready && (paddr[2] == CFG_START_LINE);
  assign prdata        = (paddr[2] == CFG_START_LINE) ? 32'(start_line) : '0;
  assign cfg_line_ext  = LW'(pwdata[LINE_FIELD_W-1:0]);
  assign tgt_ext       = LW'(tgt_q);
  assign line_next     = res_taken ? tgt_ext[LINE_BITS-1:0] : program_line + LINE_BITS'(1);
  assign line_next_ext = LW'(line_next);
  assign accept        = in_valid && in_ready;

  always_comb begin
    imm_ext = XLEN'(signed'(imm_q));
    sum     = va + imm_ext;
    sum_adj = sum[XLEN-1] ? sum + XLEN'(3) : sum;
    word_q  = {{2{sum_adj[XLEN-1]}}, sum_adj[XLEN-1:2]};
    idx_ok  = !word_q[XLEN-1] && (word_q < XLEN'(MEM_WORDS));
    prod    = va * vb;
  end

  always_comb begin
    exec_value = '0;
    exec_write = 1'b0;
    exec_taken = 1'b0;
    exec_fault = FAULT_NONE;
    unique case (act_q)
      ACT_ADD: begin
        exec_value = va + vb;
        exec_write = 1'b1;
      end
      ACT_SUB: begin
        exec_value = va - vb;
        exec_write = 1'b1;
      end
      ACT_MUL: begin
        exec_value = prod;
        exec_write = 1'b1;
      end
      ACT_DIV: begin
        if (vb == '0) begin
          exec_fault = FAULT_DIV0;
        end else begin
          exec_write = 1'b1;
        end
      end
      ACT_ADDI: begin
        exec_value = sum;
        exec_write = 1'b1;
      end
      ACT_BEQ: exec_taken = (va == vb);
      ACT_BNE: exec_taken = (va != vb);
      ACT_J:   exec_taken = 1'b1;
      ACT_LW: begin
        if (idx_ok) begin
          exec_write = 1'b1;
        end else begin
          exec_fault = FAULT_RANGE;
        end
      end
      ACT_SW: begin
        if (!idx_ok) begin
          exec_fault = FAULT_RANGE;
        end
      end
      ACT_SLT: begin
        exec_value = XLEN'($signed(va) < $signed(vb));
        exec_write = 1'b1;
      end
      ACT_LA: exec_write = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (act_q == ACT_DIV && vb != '0) begin
          state_next = ST_DIV;
        end else if (act_q == ACT_LW && idx_ok) begin
          state_next = ST_MEM;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_DONE;
        end
      end
      ST_MEM: state_next = ST_DONE;
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == ST_IDLE) && !dmem_busy;
    mem_cmd.rd = (state == ST_EXEC) && (act_q == ACT_LW) && idx_ok;
    mem_cmd.wr = (state == ST_EXEC) && (act_q == ACT_SW) && idx_ok;
    div_start = (state == ST_EXEC) && (act_q == ACT_DIV) && (vb != '0);
    retire    = (state == ST_DONE) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      out_valid    <= 1'b0;
      start_line   <= '0;
      program_line <= '0;
    end else begin
      state <= state_next;
      if (retire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_wr) begin
        start_line   <= pwdata[LINE_FIELD_W-1:0];
        program_line <= cfg_line_ext[LINE_BITS-1:0];
      end else if (retire) begin
        program_line <= line_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_q <= action;
      rd_q  <= dest_reg;
      imm_q <= immediate;
      tgt_q <= branch_target;
    end
    case (state)
      ST_EXEC: begin
        res_value <= exec_value;
        res_write <= exec_write && (rd_q != '0);
        res_taken <= exec_taken;
        res_fault <= exec_fault;
      end
      ST_DIV: begin
        if (div_done) begin
          res_value <= div_quotient;
        end
      end
      ST_MEM: res_value <= dmem_rdata;
      default: ;
    endcase
    if (retire) begin
      next_line   <= line_next_ext[LINE_FIELD_W-1:0];
      taken       <= res_taken;
      wrote       <= res_write;
      write_value <= res_write ? res_value : '0;
      fault       <= res_fault;
    end
  end

endmodule

FILE: hdl/iieu_checker.sv
// Port-level checker for the integer instruction execute unit, with its bind.
// Depends on iieu_pkg and integer_instruction_execute_unit_defines.svh.
`include "integer_instruction_execute_unit_defines.svh"

module iieu_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [iieu_pkg::LINE_FIELD_W-1:0] next_line,
  input logic                              taken,
  input logic                              wrote,
  input logic signed [iieu_pkg::XLEN-1:0]  write_value,
  input logic [1:0]                        fault
);
  import iieu_pkg::*;

  `IIEU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(next_line) && $stable(write_value) && $stable(fault), "Stalled output transaction changed.")
  `IIEU_ASSERT_NOW(a_fault_quiet, out_valid && fault != FAULT_NONE, !wrote && !taken, "Faulting instruction wrote or branched.")
  `IIEU_ASSERT_NOW(a_value_zero, out_valid && !wrote, write_value == '0, "Non-zero value without a register write.")
  `IIEU_ASSERT_NOW(a_taken_no_write, out_valid && taken, !wrote, "Taken branch also wrote a register.")

endmodule

bind integer_instruction_execute_unit iieu_checker u_iieu_checker (.*);

FILE: bench/tb_integer_instruction_execute_unit.sv
// Self-checking testbench for integer_instruction_execute_unit: predicts every output
// transaction from an in-bench copy of the registers, memory and line counter.
// Depends on iieu_pkg and the RTL under hdl/.
module tb_integer_instruction_execute_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import iieu_pkg::*;

  localparam int         MEM_DEPTH       = 1024;
  localparam int         HOLD_CYCLES     = 400;
  localparam int         SETTLE_CYCLES   = 40;
  localparam logic [3:0] ACT_LAST        = 4'd15;
  localparam logic [2:0] START_LINE_ADDR = 3'd0;

  typedef struct packed {
    logic [13:0] line;
    logic        taken;
    logic        wrote;
    logic [31:0] value;
    logic [1:0]  fault;
  } outcome_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [3:0]  action;
  logic [4:0]  dest_reg;
  logic [4:0]  source_a;
  logic [4:0]  source_b;
  logic [15:0] immediate;
  logic [13:0] branch_target;
  logic        out_valid;
  logic        out_ready;
  logic [13:0] next_line;
  logic        taken;
  logic        wrote;
  logic [31:0] write_value;
  logic [1:0]  fault;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  logic [31:0] gpr_model [32];
  logic [31:0] dmem_model [MEM_DEPTH];
  logic [13:0] line_model;
  outcome_t    pending_q[$];

  int errors        = 0;
  int src_idle_pct  = 35;
  int sink_idle_pct = 35;
  int hold_requests = 0;
  int hold_seen     = 0;
  int hold_left     = 0;

  integer_instruction_execute_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .dest_reg(dest_reg), .source_a(source_a), .source_b(source_b),
    .immediate(immediate), .branch_target(branch_target),
    .out_valid(out_valid), .out_ready(out_ready),
    .next_line(next_line), .taken(taken), .wrote(wrote),
    .write_value(write_value), .fault(fault),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("tb_integer_instruction_execute_unit: done, errors");
    $finish;
  end

  function automatic outcome_t execute_instr(input logic [3:0] act, input logic [4:0] rd,
                                             input logic [4:0] ra, input logic [4:0] rb,
                                             input logic [15:0] imm, input logic [13:0] tgt);
    logic [31:0] va;
    logic [31:0] vb;
    logic [31:0] immx;
    logic [31:0] val;
    logic [31:0] sum;
    logic        wr;
    logic        tk;
    logic [1:0]  flt;
    longint      word;
    outcome_t    o;
    va   = gpr_model[ra];
    vb   = gpr_model[rb];
    immx = {{16{imm[15]}}, imm};
    val  = '0;
    wr   = 1'b0;
    tk   = 1'b0;
    flt  = FAULT_NONE;
    case (act)
      ACT_ADD: begin
        val = va + vb;
        wr  = 1'b1;
      end
      ACT_SUB: begin
        val = va - vb;
        wr  = 1'b1;
      end
      ACT_MUL: begin
        val = va * vb;
        wr  = 1'b1;
      end
      ACT_DIV: begin
        if (vb == '0) begin
          flt = FAULT_DIV0;
        end else begin
          if (va == 32'h8000_0000 && vb == 32'hFFFF_FFFF) val = va;
          else val = $signed(va) / $signed(vb);
          wr = 1'b1;
        end
      end
      ACT_ADDI: begin
        val = va + immx;
        wr  = 1'b1;
      end
      ACT_BEQ: tk = (va == vb);
      ACT_BNE: tk = (va != vb);
      ACT_J:   tk = 1'b1;
      ACT_LW, ACT_SW: begin
        sum  = va + immx;
        word = longint'($signed(sum)) / 4;
        if (word < 0 || word >= MEM_DEPTH) begin
          flt = FAULT_RANGE;
        end else if (act == ACT_LW) begin
          val = dmem_model[word];
          wr  = 1'b1;
        end else begin
          dmem_model[word] = vb;
        end
      end
      ACT_SLT: begin
        val = ($signed(va) < $signed(vb)) ? 32'd1 : 32'd0;
        wr  = 1'b1;
      end
      ACT_LA: begin
        val = '0;
        wr  = 1'b1;
      end
      default: ;
    endcase
    if (rd == '0) wr = 1'b0;
    if (wr) gpr_model[rd] = val;
    else val = '0;
    line_model = tk ? tgt : line_model + 14'd1;
    o.line  = line_model;
    o.taken = tk;
    o.wrote = wr;
    o.value = val;
    o.fault = flt;
    return o;
  endfunction

  task automatic report_field(input string name, input logic [31:0] exp, input logic [31:0] act);
    if (exp !== act) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp, act);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    outcome_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual line %h value %h",
                 $time, next_line, write_value);
        errors++;
      end else begin
        e = pending_q.pop_front();
        report_field("next_line", 32'(e.line), 32'(next_line));
        report_field("taken", 32'(e.taken), 32'(taken));
        report_field("wrote", 32'(e.wrote), 32'(wrote));
        report_field("write_value", e.value, write_value);
        report_field("fault", 32'(e.fault), 32'(fault));
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  task automatic send_instr(input logic [3:0] act, input logic [4:0] rd, input logic [4:0] ra,
                            input logic [4:0] rb, input logic [15:0] imm,
                            input logic [13:0] tgt);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    action        <= act;
    dest_reg      <= rd;
    source_a      <= ra;
    source_b      <= rb;
    immediate     <= imm;
    branch_target <= tgt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_q.insert(pending_q.size(), execute_instr(act, rd, ra, rb, imm, tgt));
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_start_line(input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= START_LINE_ADDR;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    line_model = value[13:0];
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    report_field("prdata", {18'd0, value[13:0]}, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_random_instr;
    logic [3:0]  act;
    logic [4:0]  rd;
    logic [4:0]  ra;
    logic [4:0]  rb;
    logic [15:0] imm;
    logic [13:0] tgt;
    int          pick;
    int          want;
    int          offs;
    pick = $urandom_range(99);
    rd   = 5'($urandom);
    ra   = 5'($urandom);
    rb   = 5'($urandom);
    imm  = 16'($urandom);
    tgt  = 14'($urandom);
    if (pick < 15) begin
      act = ACT_ADDI;
      if ($urandom_range(1)) ra = '0;
    end else if (pick < 27) begin
      case ($urandom_range(3))
        0: act = ACT_ADD;
        1: act = ACT_SUB;
        2: act = ACT_MUL;
        default: act = ACT_SLT;
      endcase
    end else if (pick < 35) begin
      act = ACT_DIV;
      if ($urandom_range(4) == 0) rb = '0;
    end else if (pick < 60) begin
      act = $urandom_range(1) ? ACT_LW : ACT_SW;
      if ($urandom_range(3) != 0) begin
        want = int'($urandom_range(4099)) - 4;
        offs = want - int'($signed(gpr_model[ra]));
        if (offs >= -32768 && offs <= 32767) imm = offs[15:0];
      end
    end else if (pick < 75) begin
      act = $urandom_range(1) ? ACT_BEQ : ACT_BNE;
      if ($urandom_range(1)) rb = ra;
    end else if (pick < 87) begin
      case ($urandom_range(3))
        0: act = ACT_J;
        1: act = ACT_JR;
        2: act = ACT_LA;
        default: act = 4'($urandom_range(ACT_LAST, ACT_JR + 4'd1));
      endcase
    end else begin
      act = 4'($urandom);
    end
    send_instr(act, rd, ra, rb, imm, tgt);
  endtask

  task automatic test_directed;
    logic [3:0] a;
    send_instr(ACT_ADDI, 5'd1, 5'd0, 5'd0, 16'h8000, 14'd0);
    send_instr(ACT_ADDI, 5'd2, 5'd0, 5'd0, 16'h7FFF, 14'd0);
    send_instr(ACT_MUL, 5'd3, 5'd1, 5'd1, 16'd0, 14'd0);
    send_instr(ACT_ADD, 5'd3, 5'd3, 5'd3, 16'd0, 14'd0);
    send_instr(ACT_ADDI, 5'd4, 5'd0, 5'd0, 16'hFFFF, 14'd0);
    send_instr(ACT_DIV, 5'd5, 5'd3, 5'd4, 16'd0, 14'd0);
    send_instr(ACT_DIV, 5'd6, 5'd2, 5'd0, 16'd0, 14'd0);
    send_instr(ACT_ADDI, 5'd7, 5'd3, 5'd0, 16'hFFFF, 14'd0);
    send_instr(ACT_DIV, 5'd10, 5'd4, 5'd2, 16'd0, 14'd0);
    send_instr(ACT_SLT, 5'd8, 5'd3, 5'd7, 16'd0, 14'd0);
    send_instr(ACT_SLT, 5'd9, 5'd7, 5'd3, 16'd0, 14'd0);
    send_instr(ACT_SW, 5'd0, 5'd0, 5'd7, 16'd4092, 14'd0);
    send_instr(ACT_LW, 5'd31, 5'd0, 5'd0, 16'd4092, 14'd0);
    send_instr(ACT_SW, 5'd0, 5'd4, 5'd3, 16'hFFFE, 14'd0);
    send_instr(ACT_LW, 5'd12, 5'd4, 5'd0, 16'hFFFE, 14'd0);
    send_instr(ACT_LW, 5'd13, 5'd0, 5'd0, 16'd4096, 14'd0);
    send_instr(ACT_SW, 5'd0, 5'd0, 5'd31, 16'hFFFC, 14'd0);
    send_instr(ACT_LA, 5'd14, 5'd0, 5'd0, 16'd0, 14'd0);
    send_instr(ACT_ADD, 5'd0, 5'd2, 5'd2, 16'd0, 14'd0);
    send_instr(ACT_BEQ, 5'd0, 5'd1, 5'd1, 16'd0, 14'h3FFF);
    send_instr(ACT_BEQ, 5'd0, 5'd1, 5'd2, 16'd0, 14'h3FFF);
    send_instr(ACT_BNE, 5'd0, 5'd1, 5'd31, 16'd0, 14'd0);
    send_instr(ACT_BNE, 5'd0, 5'd31, 5'd31, 16'd0, 14'd7);
    send_instr(ACT_J, 5'd0, 5'd0, 5'd0, 16'd0, 14'd5);
    send_instr(ACT_JR, 5'd1, 5'd1, 5'd1, 16'd0, 14'd9);
    for (a = ACT_JR + 4'd1; a != 4'd0; a++) send_instr(a, 5'd2, 5'd1, 5'd2, 16'd0, 14'd3);
    drain();
  endtask

  task automatic test_line_wrap;
    write_start_line(32'h0000_3FFF);
    send_instr(ACT_JR, 5'd0, 5'd0, 5'd0, 16'd0, 14'd0);
    send_instr(ACT_J, 5'd0, 5'd0, 5'd0, 16'd0, 14'h3FFF);
    send_instr(ACT_ADDI, 5'd20, 5'd0, 5'd0, 16'd1, 14'd0);
    drain();
  endtask

  task automatic test_random_phase(input int count, input logic [31:0] start, input int idle);
    write_start_line(start);
    src_idle_pct  = idle;
    sink_idle_pct = idle;
    repeat (count) send_random_instr();
    drain();
    src_idle_pct  = 35;
    sink_idle_pct = 35;
  endtask

  task automatic test_backpressure;
    hold_requests++;
    src_idle_pct = 0;
    repeat (24) send_random_instr();
    drain();
    src_idle_pct = 35;
  endtask

  initial begin
    rst           <= 1'b1;
    in_valid      <= 1'b0;
    action        <= '0;
    dest_reg      <= '0;
    source_a      <= '0;
    source_b      <= '0;
    immediate     <= '0;
    branch_target <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    for (int i = 0; i < 32; i++) gpr_model[i] = '0;
    for (int i = 0; i < MEM_DEPTH; i++) dmem_model[i] = '0;
    line_model = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_start_line(32'd0);
    test_directed();
    test_line_wrap();
    test_random_phase(450, {18'd0, 14'($urandom)}, 35);
    test_random_phase(350, 32'd1, 0);
    test_backpressure();
    test_random_phase(450, $urandom, 35);
    test_random_phase(450, 32'h0000_3FFF, 35);

    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb_integer_instruction_execute_unit: done, clean");
    end else begin
      $display("tb_integer_instruction_execute_unit: done, errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hdl
hdl/iieu_pkg.sv
hdl/iieu_div.sv
hdl/iieu_rf.sv
hdl/iieu_dmem.sv
hdl/integer_instruction_execute_unit.sv
hdl/iieu_checker.sv
bench/tb_integer_instruction_execute_unit.sv
